// ===== src/ima_adpcm_block_decoder_defines.svh =====
// assertion helpers shared by the decoder rtl
`ifndef IMA_ADPCM_BLOCK_DECODER_DEFINES_SVH
`define IMA_ADPCM_BLOCK_DECODER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define IMABD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IMABD_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define IMABD_ASSERT(lbl, clk, rst_n, prop, msg)
`define IMABD_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== src/imabd_pkg.sv =====
`default_nettype none

package imabd_pkg;

    localparam int MAX_CHANNELS_DEF = 8;

    localparam int WORD_W       = 32;
    localparam int PRED_W       = 16;
    localparam int IDX_W        = 7;
    localparam int IDX_MAX      = 88;
    localparam int STEP_W       = 15;
    localparam int DIFF_W       = 16;
    localparam int NIB_W        = 4;
    localparam int NIB_PER_WORD = 8;
    localparam int CNT_W        = $clog2(NIB_PER_WORD);
    localparam int SAMPLE_W     = 24;
    localparam int SAMPLE_SHIFT = SAMPLE_W - PRED_W;
    localparam int CHAN_W       = 3;
    localparam int HDR_IDX_LSB  = 16;
    localparam int HDR_IDX_W    = 8;

    localparam int NUMCH_W    = 4;
    localparam int CHUNKS_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NIB_PER_WORD - 1);

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_CHUNKS       = CFG_IDX_W'(1);

    localparam logic [NUMCH_W-1:0]  NUMCH_RESET  = NUMCH_W'(1);
    localparam logic [CHUNKS_W-1:0] CHUNKS_RESET = CHUNKS_W'(63);

    typedef struct packed {
        logic signed [PRED_W-1:0] pred;
        logic [IDX_W-1:0]         idx;
    } chan_state_t;

    localparam logic [STEP_W-1:0] STEP_TABLE [IDX_MAX+1] = '{
        15'd7, 15'd8, 15'd9, 15'd10, 15'd11, 15'd12, 15'd13, 15'd14, 15'd16,
        15'd17, 15'd19, 15'd21, 15'd23, 15'd25, 15'd28, 15'd31, 15'd34, 15'd37,
        15'd41, 15'd45, 15'd50, 15'd55, 15'd60, 15'd66, 15'd73, 15'd80, 15'd88,
        15'd97, 15'd107, 15'd118, 15'd130, 15'd143, 15'd157, 15'd173, 15'd190,
        15'd209, 15'd230, 15'd253, 15'd279, 15'd307, 15'd337, 15'd371, 15'd408,
        15'd449, 15'd494, 15'd544, 15'd598, 15'd658, 15'd724, 15'd796, 15'd876,
        15'd963, 15'd1060, 15'd1166, 15'd1282, 15'd1411, 15'd1552, 15'd1707,
        15'd1878, 15'd2066, 15'd2272, 15'd2499, 15'd2749, 15'd3024, 15'd3327,
        15'd3660, 15'd4026, 15'd4428, 15'd4871, 15'd5358, 15'd5894, 15'd6484,
        15'd7132, 15'd7845, 15'd8630, 15'd9493, 15'd10442, 15'd11487, 15'd12635,
        15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350, 15'd22385,
        15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    function automatic logic [STEP_W-1:0] step_lookup(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        if (idx > IDX_W'(IDX_MAX))
        begin
            s = STEP_TABLE[IDX_MAX];
        end
        else
        begin
            s = STEP_TABLE[idx];
        end
        return s;
    endfunction

    function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
        logic signed [4:0] a;
        case (mag)
            3'd4:    a = 5'sd2;
            3'd5:    a = 5'sd4;
            3'd6:    a = 5'sd6;
            3'd7:    a = 5'sd8;
            default: a = -5'sd1;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// ===== src/imabd_ram.sv =====
`default_nettype none

module imabd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/imabd_nibble.sv =====
`default_nettype none

module imabd_nibble (
    input  imabd_pkg::chan_state_t      state_in,
    input  logic [imabd_pkg::NIB_W-1:0] nib,
    output imabd_pkg::chan_state_t      state_out
);

    import imabd_pkg::*;

    localparam int PSUM_W = PRED_W + 2;
    localparam int IDXS_W = IDX_W + 1;
    localparam logic signed [PSUM_W-1:0] SUM_HI = PSUM_W'((1 <<< (PRED_W - 1)) - 1);
    localparam logic signed [PSUM_W-1:0] SUM_LO = -SUM_HI - PSUM_W'(1);
    localparam logic signed [IDXS_W-1:0] IDX_HI = IDXS_W'(IDX_MAX);

    logic [STEP_W-1:0]        step;
    logic [DIFF_W-1:0]        diff;
    logic signed [PSUM_W-1:0] pred_ext;
    logic signed [PSUM_W-1:0] diff_ext;
    logic signed [PSUM_W-1:0] pred_sum;
    logic signed [IDXS_W-1:0] idx_sum;

    always_comb
    begin
        step = step_lookup(state_in.idx);
        diff = DIFF_W'(step >> 3);
        if (nib[0])
        begin
            diff = diff + DIFF_W'(step >> 2);
        end
        if (nib[1])
        begin
            diff = diff + DIFF_W'(step >> 1);
        end
        if (nib[2])
        begin
            diff = diff + DIFF_W'(step);
        end

        pred_ext = $signed({{2{state_in.pred[PRED_W-1]}}, state_in.pred});
        diff_ext = $signed({2'b00, diff});
        if (nib[3])
        begin
            pred_sum = pred_ext - diff_ext;
        end
        else
        begin
            pred_sum = pred_ext + diff_ext;
        end

        if (pred_sum > SUM_HI)
        begin
            state_out.pred = SUM_HI[PRED_W-1:0];
        end
        else if (pred_sum < SUM_LO)
        begin
            state_out.pred = SUM_LO[PRED_W-1:0];
        end
        else
        begin
            state_out.pred = pred_sum[PRED_W-1:0];
        end

        idx_sum = $signed({1'b0, state_in.idx}) + IDXS_W'(index_adjust(nib[2:0]));
        if (idx_sum < 0)
        begin
            state_out.idx = '0;
        end
        else if (idx_sum > IDX_HI)
        begin
            state_out.idx = IDX_W'(IDX_MAX);
        end
        else
        begin
            state_out.idx = idx_sum[IDX_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== src/imabd_seq.sv =====
`default_nettype none

module imabd_seq #(
    parameter int MAX_CHANNELS = imabd_pkg::MAX_CHANNELS_DEF,
    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [imabd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [imabd_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                step,
    output logic [CH_W-1:0]                     ch,
    output logic                                hdr
);

    import imabd_pkg::*;

    localparam int EFF_W = NUMCH_W + 1;
    localparam logic [EFF_W-1:0] MAX_C = EFF_W'(MAX_CHANNELS);

    function automatic logic [EFF_W-1:0] eff_of(input logic [NUMCH_W-1:0] n);
        logic [EFF_W-1:0] v;
        v = EFF_W'(n);
        if (v == '0)
        begin
            v = EFF_W'(1);
        end
        if (v > MAX_C)
        begin
            v = MAX_C;
        end
        return v;
    endfunction

    logic [NUMCH_W-1:0]  num_channels_reg, num_channels_next;
    logic [CHUNKS_W-1:0] chunks_reg, chunks_next;
    logic [CH_W-1:0]     cur_ch_reg, cur_ch_next;
    logic [CHUNKS_W-1:0] block_pos_reg, block_pos_next;

    logic [EFF_W-1:0]    eff_cur;
    logic [EFF_W-1:0]    ch_inc;
    logic [CHUNKS_W-1:0] eff_chunks;
    logic [CH_W-1:0]     ch_use;

    assign eff_cur    = eff_of(num_channels_reg);
    assign ch_use     = (EFF_W'(cur_ch_reg) >= eff_cur) ? '0 : cur_ch_reg;
    assign ch_inc     = EFF_W'(ch_use) + EFF_W'(1);
    assign eff_chunks = (chunks_reg == '0) ? CHUNKS_W'(1) : chunks_reg;
    assign ch         = ch_use;
    assign hdr        = (block_pos_reg == '0);

    always_comb
    begin
        num_channels_next = num_channels_reg;
        chunks_next       = chunks_reg;
        cur_ch_next       = cur_ch_reg;
        block_pos_next    = block_pos_reg;

        if (step)
        begin
            if (ch_inc >= eff_cur)
            begin
                cur_ch_next = '0;
                if (block_pos_reg == '0)
                begin
                    block_pos_next = CHUNKS_W'(1);
                end
                else if (block_pos_reg >= eff_chunks)
                begin
                    block_pos_next = '0;
                end
                else
                begin
                    block_pos_next = block_pos_reg + CHUNKS_W'(1);
                end
            end
            else
            begin
                cur_ch_next = ch_inc[CH_W-1:0];
            end
        end

        if (cfg_write)
        begin
            case (cfg_index)
                REG_NUM_CHANNELS:
                begin
                    num_channels_next = cfg_data[NUMCH_W-1:0];
                    // fewer channels than the current position: restart at channel 0
                    if (EFF_W'(cur_ch_next) >= eff_of(cfg_data[NUMCH_W-1:0]))
                    begin
                        cur_ch_next = '0;
                    end
                end
                REG_CHUNKS:
                begin
                    chunks_next = cfg_data[CHUNKS_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_channels_reg <= NUMCH_RESET;
            chunks_reg       <= CHUNKS_RESET;
            cur_ch_reg       <= '0;
            block_pos_reg    <= '0;
        end
        else
        begin
            num_channels_reg <= num_channels_next;
            chunks_reg       <= chunks_next;
            cur_ch_reg       <= cur_ch_next;
            block_pos_reg    <= block_pos_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/ima_adpcm_block_decoder.sv =====
// channel   direction  handshake                 payload
// input     in         in_valid / in_stall       data_word
// output    out        out_valid / out_stall     channel, sample, last_of_word
// config    in         cfg_valid / cfg_ready     cfg_index, cfg_data
//
// a data word goes one nibble per unstalled cycle through the single decode unit,
// each nibble needing the predictor and index left by the one before it
// a header word passes through the decode stage and gives no sample
// channel state is read from the state ram ahead of decode into a one-entry pending
// slot, so back-to-back data words keep the decode unit busy every unstalled cycle
// reset clears the per-channel valid flags at once; no clearing pass
// out_stall holds the decode loop; in_stall rises while the pending slot is full and cannot move on
`default_nettype none

module ima_adpcm_block_decoder #(
    parameter int MAX_CHANNELS = imabd_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  logic [imabd_pkg::WORD_W-1:0]          data_word,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output logic [imabd_pkg::CHAN_W-1:0]          channel,
    output logic signed [imabd_pkg::SAMPLE_W-1:0] sample,
    output logic                                  last_of_word,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [imabd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [imabd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import imabd_pkg::*;
`include "ima_adpcm_block_decoder_defines.svh"

    localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

    logic            in_accept;
    logic [CH_W-1:0] seq_ch;
    logic            seq_hdr;

    chan_state_t ram_rdata;
    chan_state_t wr_state;
    chan_state_t dec_state;
    chan_state_t p_state;
    chan_state_t hdr_state;
    chan_state_t load_state;

    // pending slot
    logic              p_valid_reg, p_valid_next;
    logic [WORD_W-1:0] p_word_reg, p_word_next;
    logic [CH_W-1:0]   p_ch_reg, p_ch_next;
    logic              p_hdr_reg, p_hdr_next;
    logic              fwd_hit_reg, fwd_hit_next;
    chan_state_t       fwd_state_reg, fwd_state_next;
    logic              rd_vld_reg, rd_vld_next;

    // decode stage
    logic              ex_busy_reg, ex_busy_next;
    logic              ex_hdr_reg, ex_hdr_next;
    logic [CNT_W-1:0]  ex_cnt_reg, ex_cnt_next;
    logic [WORD_W-1:0] ex_word_reg, ex_word_next;
    logic [CH_W-1:0]   ex_ch_reg, ex_ch_next;
    chan_state_t       ex_state_reg, ex_state_next;

    logic [MAX_CHANNELS-1:0] vld_reg, vld_next;

    // output register
    logic                       out_valid_reg, out_valid_next;
    logic [CHAN_W-1:0]          out_ch_reg, out_ch_next;
    logic signed [SAMPLE_W-1:0] out_sample_reg, out_sample_next;
    logic                       out_last_reg, out_last_next;

    logic                   out_free;
    logic                   ex_step;
    logic                   ex_done;
    logic                   p_move;
    logic [HDR_IDX_W-1:0]   hdr_idx_raw;
    logic [CH_W+CHAN_W-1:0] ex_ch_wide;

    assign cfg_ready = 1'b1;

    assign out_free  = !out_valid_reg || !out_stall;
    assign ex_step   = ex_busy_reg && !ex_hdr_reg && out_free;
    assign ex_done   = ex_busy_reg && (ex_hdr_reg || (out_free && ex_cnt_reg == CNT_LAST));
    assign p_move    = p_valid_reg && (!ex_busy_reg || ex_done);
    assign in_stall  = p_valid_reg && !p_move;
    assign in_accept = in_valid && !in_stall;

    assign wr_state  = ex_hdr_reg ? ex_state_reg : dec_state;

    imabd_seq #(
        .MAX_CHANNELS(MAX_CHANNELS)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_valid && cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .step     (in_accept),
        .ch       (seq_ch),
        .hdr      (seq_hdr)
    );

    imabd_ram #(
        .WIDTH($bits(chan_state_t)),
        .DEPTH(MAX_CHANNELS)
    ) u_state_ram (
        .clk    (clk),
        .wr_en  (ex_done),
        .wr_addr(ex_ch_reg),
        .wr_data(wr_state),
        .rd_en  (in_accept),
        .rd_addr(seq_ch),
        .rd_data(ram_rdata)
    );

    imabd_nibble u_nibble (
        .state_in (ex_state_reg),
        .nib      (ex_word_reg[NIB_W-1:0]),
        .state_out(dec_state)
    );

    // fetched state: write at the read edge wins, never-written entry reads zero
    always_comb
    begin
        if (fwd_hit_reg)
        begin
            p_state = fwd_state_reg;
        end
        else if (rd_vld_reg)
        begin
            p_state = ram_rdata;
        end
        else
        begin
            p_state = '0;
        end
    end

    assign hdr_idx_raw    = p_word_reg[HDR_IDX_LSB +: HDR_IDX_W];
    assign hdr_state.pred = p_word_reg[PRED_W-1:0];
    assign hdr_state.idx  = (hdr_idx_raw > HDR_IDX_W'(IDX_MAX)) ? IDX_W'(IDX_MAX)
                                                                : hdr_idx_raw[IDX_W-1:0];

    // header word: state from the word; same channel finishing in the decode stage this cycle: take its result
    always_comb
    begin
        if (p_hdr_reg)
        begin
            load_state = hdr_state;
        end
        else if (ex_done && ex_ch_reg == p_ch_reg)
        begin
            load_state = wr_state;
        end
        else
        begin
            load_state = p_state;
        end
    end

    always_comb
    begin
        p_valid_next   = p_valid_reg;
        p_word_next    = p_word_reg;
        p_ch_next      = p_ch_reg;
        p_hdr_next     = p_hdr_reg;
        fwd_hit_next   = fwd_hit_reg;
        fwd_state_next = fwd_state_reg;
        rd_vld_next    = rd_vld_reg;
        if (p_move)
        begin
            p_valid_next = 1'b0;
        end
        if (in_accept)
        begin
            p_valid_next   = 1'b1;
            p_word_next    = data_word;
            p_ch_next      = seq_ch;
            p_hdr_next     = seq_hdr;
            fwd_hit_next   = ex_done && (ex_ch_reg == seq_ch);
            fwd_state_next = wr_state;
            rd_vld_next    = vld_reg[seq_ch];
        end
    end

    always_comb
    begin
        ex_busy_next  = ex_busy_reg;
        ex_hdr_next   = ex_hdr_reg;
        ex_cnt_next   = ex_cnt_reg;
        ex_word_next  = ex_word_reg;
        ex_ch_next    = ex_ch_reg;
        ex_state_next = ex_state_reg;
        if (p_move)
        begin
            ex_busy_next  = 1'b1;
            ex_hdr_next   = p_hdr_reg;
            ex_cnt_next   = '0;
            ex_word_next  = p_word_reg;
            ex_ch_next    = p_ch_reg;
            ex_state_next = load_state;
        end
        else if (ex_done)
        begin
            ex_busy_next = 1'b0;
        end
        else if (ex_step)
        begin
            ex_state_next = dec_state;
            ex_cnt_next   = ex_cnt_reg + CNT_W'(1);
            ex_word_next  = {{NIB_W{1'b0}}, ex_word_reg[WORD_W-1:NIB_W]};
        end
    end

    always_comb
    begin
        vld_next = vld_reg;
        if (ex_done)
        begin
            vld_next[ex_ch_reg] = 1'b1;
        end
    end

    assign ex_ch_wide = {{CHAN_W{1'b0}}, ex_ch_reg};

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_ch_next     = out_ch_reg;
        out_sample_next = out_sample_reg;
        out_last_next   = out_last_reg;
        if (ex_step)
        begin
            out_valid_next  = 1'b1;
            out_ch_next     = ex_ch_wide[CHAN_W-1:0];
            out_sample_next = {dec_state.pred, {SAMPLE_SHIFT{1'b0}}};
            out_last_next   = (ex_cnt_reg == CNT_LAST);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            rd_vld_reg    <= 1'b0;
            ex_busy_reg   <= 1'b0;
            ex_hdr_reg    <= 1'b0;
            ex_cnt_reg    <= '0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            p_valid_reg   <= p_valid_next;
            fwd_hit_reg   <= fwd_hit_next;
            rd_vld_reg    <= rd_vld_next;
            ex_busy_reg   <= ex_busy_next;
            ex_hdr_reg    <= ex_hdr_next;
            ex_cnt_reg    <= ex_cnt_next;
            vld_reg       <= vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_word_reg     <= p_word_next;
        p_ch_reg       <= p_ch_next;
        p_hdr_reg      <= p_hdr_next;
        fwd_state_reg  <= fwd_state_next;
        ex_word_reg    <= ex_word_next;
        ex_ch_reg      <= ex_ch_next;
        ex_state_reg   <= ex_state_next;
        out_ch_reg     <= out_ch_next;
        out_sample_reg <= out_sample_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign channel      = out_ch_reg;
    assign sample       = out_sample_reg;
    assign last_of_word = out_last_reg;

    `IMABD_ASSERT(a_word_in_flight_shows, clk, rst_n, ex_busy_reg && !ex_hdr_reg && ex_cnt_reg != '0 |-> out_valid_reg, "data word in flight without a pending sample")
    `IMABD_ASSERT(a_done_gives_last, clk, rst_n, ex_done && !ex_hdr_reg |=> out_valid_reg && out_last_reg, "finished data word did not leave its last sample")
    `IMABD_ASSERT(a_writeback_marks_valid, clk, rst_n, ex_done |=> vld_reg[$past(ex_ch_reg)], "state write did not mark the channel valid")

endmodule

`default_nettype wire
